[src/mspp_pkg.sv]
// ----------------------------------------------------------------------------
// mspp_pkg
// shared types and constants of the multipath score path picker
// ----------------------------------------------------------------------------
`default_nettype none
package mspp_pkg;

    localparam int MAX_PATHS   = 8;
    localparam int CNT_W       = 4;
    localparam int IDENT_W     = 8;
    localparam int BYTES_W     = 32;
    localparam int RTT_W       = 32;
    localparam int SCORE_W     = 42;
    localparam int SHIFT_BITS  = 10;
    localparam int DIVCNT_W    = 6;

    localparam logic [1:0] STATUS_AVAIL   = 2'd0;
    localparam logic [1:0] STATUS_STANDBY = 2'd1;
    localparam logic [1:0] STATUS_FROZEN  = 2'd2;

    localparam logic [1:0] CLASS_AVAIL    = 2'd0;
    localparam logic [1:0] CLASS_STANDBY  = 2'd1;
    localparam logic [1:0] CLASS_ORIGINAL = 2'd2;
    localparam logic [1:0] CLASS_NONE     = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the input word
        logic div_start;  // begin score division
        logic div_step;   // one quotient bit
        logic update;     // fold captured path into round state
        logic emit;       // build the result word
        logic clear;      // clear round state
    } mspp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic needs_div;  // captured path needs a score
        logic div_done;   // last quotient bit taken
        logic last;       // captured word closes the round
    } mspp_stat_t;

endpackage
`default_nettype wire

[src/mspp_datapath.sv]
// ----------------------------------------------------------------------------
// mspp_datapath
// path capture, restoring divider for the score and per-class best tracking
// ----------------------------------------------------------------------------
`default_nettype none
module mspp_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire mspp_pkg::mspp_cmd_t           cmd,
    output mspp_pkg::mspp_stat_t               stat,
    input  wire logic [mspp_pkg::IDENT_W-1:0]  s_path_ident,
    input  wire logic                          s_path_active,
    input  wire logic [1:0]                    s_app_status,
    input  wire logic                          s_path_can_send,
    input  wire logic [mspp_pkg::BYTES_W-1:0]  s_cwnd_bytes,
    input  wire logic [mspp_pkg::BYTES_W-1:0]  s_inflight_bytes,
    input  wire logic [mspp_pkg::BYTES_W-1:0]  s_scheduled_bytes,
    input  wire logic [mspp_pkg::RTT_W-1:0]    s_smoothed_rtt,
    input  wire logic                          s_is_reinject,
    input  wire logic [mspp_pkg::IDENT_W-1:0]  s_packet_path_ident,
    input  wire logic                          s_need_diff_path,
    input  wire logic                          s_last_path,
    output logic                               m_found,
    output logic [mspp_pkg::IDENT_W-1:0]       m_chosen_ident,
    output logic [1:0]                         m_chosen_class,
    output logic [mspp_pkg::SCORE_W-1:0]       m_best_score,
    output logic                               m_congestion_blocked
);
    import mspp_pkg::*;

    localparam int NUM_W = BYTES_W + SHIFT_BITS;

    // captured word
    logic [IDENT_W-1:0] id_reg;
    logic [1:0]         status_reg;
    logic               elig_reg, send_reg, orig_reg, diff_reg, last_reg;
    logic [BYTES_W-1:0] head_reg;
    logic [RTT_W-1:0]   rtt_reg;

    // divider
    logic [NUM_W-1:0]   quo_reg;
    logic [RTT_W:0]     rem_reg;
    logic [DIVCNT_W-1:0] cnt_reg;

    // round state
    logic [IDENT_W-1:0] a_id_reg, s_id_reg, o_id_reg;
    logic [SCORE_W-1:0] a_sc_reg, s_sc_reg;
    logic [RTT_W-1:0]   a_rtt_reg, s_rtt_reg;
    logic [CNT_W-1:0]   a_cnt_reg, s_cnt_reg;
    logic               o_val_reg, blk_reg, seen_reg;
    logic [IDENT_W:0]   prev_reg;

    logic [BYTES_W:0]   used;
    logic [BYTES_W-1:0] head_in;
    logic [RTT_W:0]     trial;
    logic [SCORE_W-1:0] score;
    logic               a_take, s_take, scoring;

    assign used    = {1'b0, s_scheduled_bytes} + {1'b0, s_inflight_bytes};
    assign head_in = ({1'b0, s_cwnd_bytes} > used) ?
                     (s_cwnd_bytes - used[BYTES_W-1:0]) : '0;
    assign trial   = {rem_reg[RTT_W-1:0], quo_reg[NUM_W-1]};

    always_comb begin
        score = quo_reg;
        if (quo_reg == '0 && head_reg != '0) begin
            score = SCORE_W'(1);
        end
    end

    assign scoring = elig_reg && send_reg && !orig_reg;

    function automatic logic beats(input logic [SCORE_W-1:0] sc,
                                   input logic [RTT_W-1:0] rt,
                                   input logic [IDENT_W-1:0] id,
                                   input logic [SCORE_W-1:0] bsc,
                                   input logic [RTT_W-1:0] brt,
                                   input logic [IDENT_W-1:0] bid);
        logic r;
        if (sc != bsc)      r = sc > bsc;
        else if (rt != brt) r = rt < brt;
        else                r = id < bid;
        return r;
    endfunction

    assign a_take = scoring && status_reg == STATUS_AVAIL &&
                    a_cnt_reg < CNT_W'(MAX_PATHS);
    assign s_take = scoring && status_reg == STATUS_STANDBY &&
                    s_cnt_reg < CNT_W'(MAX_PATHS);

    assign stat.needs_div = scoring;
    assign stat.div_done  = cnt_reg == DIVCNT_W'(NUM_W - 1);
    assign stat.last      = last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            id_reg     <= s_path_ident;
            status_reg <= s_app_status;
            elig_reg   <= s_path_active && s_app_status != STATUS_FROZEN;
            send_reg   <= s_path_can_send;
            orig_reg   <= s_is_reinject && s_packet_path_ident == s_path_ident;
            diff_reg   <= s_need_diff_path;
            last_reg   <= s_last_path;
            head_reg   <= head_in;
            rtt_reg    <= (s_smoothed_rtt == '0) ? RTT_W'(1) : s_smoothed_rtt;
        end
        if (cmd.div_start) begin
            quo_reg <= {head_reg, {SHIFT_BITS{1'b0}}};
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            if (trial >= {1'b0, rtt_reg}) begin
                rem_reg <= trial - {1'b0, rtt_reg};
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + DIVCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            a_cnt_reg <= '0;
            s_cnt_reg <= '0;
            o_val_reg <= 1'b0;
            blk_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            a_id_reg  <= '0;
            s_id_reg  <= '0;
            o_id_reg  <= '0;
            a_sc_reg  <= '0;
            s_sc_reg  <= '0;
            a_rtt_reg <= '0;
            s_rtt_reg <= '0;
            if (!aresetn) begin
                prev_reg <= '0;
            end
        end else if (cmd.update) begin
            if (elig_reg) begin
                seen_reg <= 1'b1;
                if (send_reg) begin
                    blk_reg <= 1'b0;
                end else if (!seen_reg) begin
                    blk_reg <= 1'b1;
                end
                if (send_reg && orig_reg) begin
                    o_val_reg <= 1'b1;
                    o_id_reg  <= id_reg;
                end
            end
            if (a_take) begin
                if (a_cnt_reg == '0 ||
                    beats(score, rtt_reg, id_reg, a_sc_reg, a_rtt_reg, a_id_reg)) begin
                    a_id_reg  <= id_reg;
                    a_sc_reg  <= score;
                    a_rtt_reg <= rtt_reg;
                end
                a_cnt_reg <= a_cnt_reg + CNT_W'(1);
            end
            if (s_take) begin
                if (s_cnt_reg == '0 ||
                    beats(score, rtt_reg, id_reg, s_sc_reg, s_rtt_reg, s_id_reg)) begin
                    s_id_reg  <= id_reg;
                    s_sc_reg  <= score;
                    s_rtt_reg <= rtt_reg;
                end
                s_cnt_reg <= s_cnt_reg + CNT_W'(1);
            end
        end
        if (aresetn && cmd.emit) begin
            if (a_cnt_reg != '0) begin
                prev_reg <= {1'b1, a_id_reg};
            end else if (s_cnt_reg != '0) begin
                prev_reg <= {1'b1, s_id_reg};
            end
        end
    end

    // result word, held until the next emit
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_congestion_blocked <= blk_reg;
            if (a_cnt_reg != '0) begin
                m_found <= 1'b1; m_chosen_ident <= a_id_reg;
                m_chosen_class <= CLASS_AVAIL; m_best_score <= a_sc_reg;
            end else if (s_cnt_reg != '0) begin
                m_found <= 1'b1; m_chosen_ident <= s_id_reg;
                m_chosen_class <= CLASS_STANDBY; m_best_score <= s_sc_reg;
            end else if (o_val_reg && !diff_reg) begin
                m_found <= 1'b1; m_chosen_ident <= o_id_reg;
                m_chosen_class <= CLASS_ORIGINAL; m_best_score <= '0;
            end else begin
                m_found <= 1'b0; m_chosen_ident <= '0;
                m_chosen_class <= CLASS_NONE; m_best_score <= '0;
            end
        end
    end

    // previous choice is kept for observability only
    logic prev_unused;
    assign prev_unused = ^prev_reg;

endmodule
`default_nettype wire

[src/mspp_ctrl.sv]
// ----------------------------------------------------------------------------
// mspp_ctrl
// sequencer: capture, divide, fold, and result handshake
// ----------------------------------------------------------------------------
`default_nettype none
module mspp_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire mspp_pkg::mspp_stat_t stat,
    output mspp_pkg::mspp_cmd_t       cmd
);
    import mspp_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;

    assign m_valid = mvalid_reg;
    // emit needs a free output register
    assign s_ready = state_reg == ST_IDLE;

    always_comb begin
        state_next    = state_reg;
        mvalid_next   = mvalid_reg;
        cmd           = '0;
        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (stat.needs_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_UPDATE;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = stat.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!mvalid_reg || m_ready) begin
                    cmd.emit    = 1'b1;
                    cmd.clear   = 1'b1;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule
`default_nettype wire

[src/multipath_score_path_picker.sv]
// ----------------------------------------------------------------------------
// multipath_score_path_picker
// scores a round of path descriptors and picks the path for one packet
// ----------------------------------------------------------------------------
// channel | direction | contents
// s_      | in        | one path descriptor word, last_path closes round
// m_      | out       | one pick word per round
//
// a path word is captured, scored if it needs a score, then folded in:
// the 42-step restoring divider (one quotient bit a cycle) computes the score
// the closing word also goes through an emit step that builds the pick word
// reset (synchronous, aresetn low) clears round state and previous choice
// a stalled m_ side holds the pick word; the next round is taken, but its emit waits
`default_nettype none
module multipath_score_path_picker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_path_ident,
    input  wire logic         s_path_active,
    input  wire logic [1:0]   s_app_status,
    input  wire logic         s_path_can_send,
    input  wire logic [31:0]  s_cwnd_bytes,
    input  wire logic [31:0]  s_inflight_bytes,
    input  wire logic [31:0]  s_scheduled_bytes,
    input  wire logic [31:0]  s_smoothed_rtt,
    input  wire logic         s_is_reinject,
    input  wire logic [7:0]   s_packet_path_ident,
    input  wire logic         s_need_diff_path,
    input  wire logic         s_last_path,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic              m_found,
    output logic [7:0]        m_chosen_ident,
    output logic [1:0]        m_chosen_class,
    output logic [41:0]       m_best_score,
    output logic              m_congestion_blocked
);
    import mspp_pkg::*;

    mspp_cmd_t  cmd;   // sequencer commands
    mspp_stat_t stat;  // datapath status

    // controller: handshakes and step sequencing
    mspp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: headroom, divider, class trackers, result register
    mspp_datapath u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .stat                 (stat),
        .s_path_ident         (s_path_ident),
        .s_path_active        (s_path_active),
        .s_app_status         (s_app_status),
        .s_path_can_send      (s_path_can_send),
        .s_cwnd_bytes         (s_cwnd_bytes),
        .s_inflight_bytes     (s_inflight_bytes),
        .s_scheduled_bytes    (s_scheduled_bytes),
        .s_smoothed_rtt       (s_smoothed_rtt),
        .s_is_reinject        (s_is_reinject),
        .s_packet_path_ident  (s_packet_path_ident),
        .s_need_diff_path     (s_need_diff_path),
        .s_last_path          (s_last_path),
        .m_found              (m_found),
        .m_chosen_ident       (m_chosen_ident),
        .m_chosen_class       (m_chosen_class),
        .m_best_score         (m_best_score),
        .m_congestion_blocked (m_congestion_blocked)
    );

endmodule
`default_nettype wire

[src/mspp_checker.sv]
// ----------------------------------------------------------------------------
// mspp_checker
// port-level checks of the picker, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
module mspp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_found,
    input wire logic [7:0]  m_chosen_ident,
    input wire logic [1:0]  m_chosen_class,
    input wire logic [41:0] m_best_score
);
    import mspp_pkg::*;

    // a held word stays valid and keeps its ident
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_chosen_ident))
        else $error("result word changed under stall");

    // no pick means class none
    a_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_chosen_class == CLASS_NONE && m_chosen_ident == '0)
        else $error("empty pick inconsistent");

    // original and none carry no score
    a_score: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_chosen_class == CLASS_ORIGINAL || m_chosen_class == CLASS_NONE)
        |-> m_best_score == '0)
        else $error("score on unscored class");

    // an accepted word is not taken in the next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after accept");

endmodule

bind multipath_score_path_picker mspp_checker u_mspp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_found        (m_found),
    .m_chosen_ident (m_chosen_ident),
    .m_chosen_class (m_chosen_class),
    .m_best_score   (m_best_score)
);
`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// path picker check: rounds of path words in, one pick word per round out,
// compared field by field against a behavioral scorer kept in the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import mspp_pkg::*;

    // one path descriptor word
    typedef struct {
        logic [7:0]  ident;
        logic        active;
        logic [1:0]  status;
        logic        can_send;
        logic [31:0] cwnd;
        logic [31:0] inflight;
        logic [31:0] sched;
        logic [31:0] rtt;
        logic        reinject;
        logic [7:0]  pkt_ident;
        logic        diff;
        logic        last;
    } path_word_t;

    // one pick word
    typedef struct {
        logic        found;
        logic [7:0]  ident;
        logic [1:0]  cls;
        logic [41:0] score;
        logic        blocked;
    } pick_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    path_word_t  s_word;
    logic        m_valid;
    logic        m_ready;
    logic        m_found;
    logic [7:0]  m_chosen_ident;
    logic [1:0]  m_chosen_class;
    logic [41:0] m_best_score;
    logic        m_congestion_blocked;

    path_word_t  pending_words[$];
    pick_word_t  expected_picks[$];
    int          error_count;
    bit          stim_done;
    bit          hold_sender;
    bit          s_accepted;

    // scorer state for the round in progress
    logic [7:0]  av_ident, sb_ident, orig_ident;
    logic [41:0] av_score, sb_score;
    logic [31:0] av_rtt, sb_rtt;
    int          av_cnt, sb_cnt;
    bit          orig_valid, blocked, elig_seen;

    multipath_score_path_picker DUT (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_path_ident         (s_word.ident),
        .s_path_active        (s_word.active),
        .s_app_status         (s_word.status),
        .s_path_can_send      (s_word.can_send),
        .s_cwnd_bytes         (s_word.cwnd),
        .s_inflight_bytes     (s_word.inflight),
        .s_scheduled_bytes    (s_word.sched),
        .s_smoothed_rtt       (s_word.rtt),
        .s_is_reinject        (s_word.reinject),
        .s_packet_path_ident  (s_word.pkt_ident),
        .s_need_diff_path     (s_word.diff),
        .s_last_path          (s_word.last),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_found              (m_found),
        .m_chosen_ident       (m_chosen_ident),
        .m_chosen_class       (m_chosen_class),
        .m_best_score         (m_best_score),
        .m_congestion_blocked (m_congestion_blocked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    function automatic bit path_beats(logic [41:0] sc, logic [31:0] rtt, logic [7:0] id,
                                      logic [41:0] bsc, logic [31:0] brtt,
                                      logic [7:0] bid);
        if (sc != bsc) return sc > bsc;
        if (rtt != brtt) return rtt < brtt;
        return id < bid;
    endfunction

    function automatic void clear_round();
        av_cnt = 0; sb_cnt = 0; av_ident = '0; sb_ident = '0;
        av_score = '0; sb_score = '0; av_rtt = '0; sb_rtt = '0;
        orig_valid = 0; orig_ident = '0; blocked = 0; elig_seen = 0;
    endfunction

    // fold one accepted path word into the round, queue a pick on the last
    function automatic void score_path(path_word_t w);
        logic [32:0]  used;
        logic [31:0]  head, srtt;
        logic [41:0]  sc;
        logic [63:0]  quot;
        pick_word_t   p;
        if (w.active && w.status != STATUS_FROZEN) begin
            if (!elig_seen) begin
                elig_seen = 1;
                blocked = 1;
            end
            if (w.can_send) begin
                blocked = 0;
                if (w.reinject && w.pkt_ident == w.ident) begin
                    orig_valid = 1;
                    orig_ident = w.ident;
                end else begin
                    used = {1'b0, w.sched} + {1'b0, w.inflight};
                    head = ({1'b0, w.cwnd} > used) ? w.cwnd - used[31:0] : '0;
                    srtt = (w.rtt == 0) ? 32'd1 : w.rtt;
                    quot = ({32'd0, head} << SHIFT_BITS) / {32'd0, srtt};
                    sc = quot[41:0];
                    if (sc == 0 && head != 0) sc = 42'd1;
                    if (w.status == STATUS_AVAIL && av_cnt < MAX_PATHS) begin
                        if (av_cnt == 0 || path_beats(sc, srtt, w.ident,
                                                      av_score, av_rtt, av_ident)) begin
                            av_ident = w.ident; av_score = sc; av_rtt = srtt;
                        end
                        av_cnt++;
                    end else if (w.status == STATUS_STANDBY && sb_cnt < MAX_PATHS) begin
                        if (sb_cnt == 0 || path_beats(sc, srtt, w.ident,
                                                      sb_score, sb_rtt, sb_ident)) begin
                            sb_ident = w.ident; sb_score = sc; sb_rtt = srtt;
                        end
                        sb_cnt++;
                    end
                end
            end
        end
        if (!w.last) return;
        p = '{1'b0, 8'd0, CLASS_NONE, 42'd0, blocked};
        if (av_cnt > 0) p = '{1'b1, av_ident, CLASS_AVAIL, av_score, blocked};
        else if (sb_cnt > 0) p = '{1'b1, sb_ident, CLASS_STANDBY, sb_score, blocked};
        else if (orig_valid && !w.diff) p = '{1'b1, orig_ident, CLASS_ORIGINAL, 42'd0, blocked};
        expected_picks.push_back(p);
        clear_round();
    endfunction

    function automatic logic [31:0] rand_bytes();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 5000);
            3: return $urandom_range(0, 200000);
            default: return $urandom;
        endcase
    endfunction

    function automatic path_word_t rand_path(logic [7:0] id, bit reinj, logic [7:0] pkt,
                                             bit diff, bit last);
        path_word_t w;
        w.ident     = id;
        w.active    = ($urandom_range(0, 9) != 0);
        w.status    = ($urandom_range(0, 9) < 6) ? STATUS_AVAIL : 2'($urandom_range(0, 3));
        w.can_send  = ($urandom_range(0, 5) != 0);
        w.cwnd      = rand_bytes();
        w.inflight  = ($urandom_range(0, 2) == 0) ? rand_bytes() : 32'($urandom_range(0, 3000));
        w.sched     = ($urandom_range(0, 2) == 0) ? rand_bytes() : 32'($urandom_range(0, 3000));
        w.rtt       = ($urandom_range(0, 7) == 0) ? 32'd0 : rand_bytes();
        w.reinject  = reinj;
        w.pkt_ident = pkt;
        w.diff      = diff;
        w.last      = last;
        return w;
    endfunction

    // a round of distinct idents, shared packet fields; noise words may vary
    task automatic queue_round(int n);
        logic [7:0] ids[$];
        logic [7:0] id, pkt;
        bit         reinj, diff, noisy;
        reinj = $urandom_range(0, 2) == 0;
        diff  = 1'($urandom_range(0, 1));
        noisy = $urandom_range(0, 19) == 0;
        while (ids.size() < n) begin
            id = 8'($urandom);
            if (!(id inside {ids})) ids.push_back(id);
        end
        pkt = ($urandom_range(0, 1) != 0) ? ids[$urandom_range(0, n - 1)] : 8'($urandom);
        for (int i = 0; i < n; i++) begin
            if (noisy) begin
                reinj = 1'($urandom_range(0, 1));
                diff  = 1'($urandom_range(0, 1));
            end
            pending_words.push_back(rand_path(ids[i], reinj, pkt, diff, i == n - 1));
        end
    endtask

    function automatic path_word_t mk(logic [7:0] id, logic [1:0] st, logic [31:0] cwnd,
                                      logic [31:0] rtt, bit last);
        return '{id, 1'b1, st, 1'b1, cwnd, 32'd0, 32'd0, rtt, 1'b0, 8'd0, 1'b0, last};
    endfunction

    // stimulus
    initial begin
        path_word_t w;
        int         n;
        int         total_words;
        clear_round();
        error_count = 0;
        stim_done   = 0;
        hold_sender = 0;
        aresetn     = 1'b0;
        // directed: extremes, zero rtt, headroom floor, tiny score raised to 1
        pending_words.push_back('{8'hFF, 1'b1, STATUS_AVAIL, 1'b1, 32'hFFFF_FFFF,
                                  32'd0, 32'd0, 32'd0, 1'b1, 8'h00, 1'b1, 1'b1});
        pending_words.push_back('{8'h00, 1'b1, STATUS_AVAIL, 1'b1, 32'd100, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 8'hFF, 1'b0, 1'b1});
        pending_words.push_back(mk(8'd3, STATUS_AVAIL, 32'd1, 32'hFFFF_FFFF, 1'b1));
        // ties on score then rtt then ident, plus standby beaten by available
        pending_words.push_back(mk(8'd9, STATUS_AVAIL, 32'd1000, 32'd10, 1'b0));
        pending_words.push_back(mk(8'd5, STATUS_AVAIL, 32'd2000, 32'd20, 1'b0));
        pending_words.push_back(mk(8'd7, STATUS_AVAIL, 32'd1000, 32'd10, 1'b0));
        pending_words.push_back(mk(8'd1, STATUS_STANDBY, 32'hFFFF, 32'd1, 1'b1));
        // standby only, with a status-other path that joins no class
        pending_words.push_back(mk(8'd4, 2'd3, 32'h7FFF, 32'd1, 1'b0));
        pending_words.push_back(mk(8'd2, STATUS_STANDBY, 32'd500, 32'd3, 1'b1));
        // blocked: eligible path that cannot send, frozen, inactive
        w = mk(8'd6, STATUS_AVAIL, 32'd500, 32'd3, 1'b0); w.can_send = 0;
        pending_words.push_back(w);
        w = mk(8'd8, STATUS_FROZEN, 32'd500, 32'd3, 1'b0);
        pending_words.push_back(w);
        w = mk(8'd10, STATUS_AVAIL, 32'd500, 32'd3, 1'b1); w.active = 0;
        pending_words.push_back(w);
        // reinjection on the original path, allowed then refused
        for (int k = 0; k < 2; k++) begin
            w = mk(8'd20, STATUS_AVAIL, 32'd500, 32'd3, 1'b0);
            w.reinject = 1; w.pkt_ident = 8'd20; w.diff = 1'(k);
            pending_words.push_back(w);
            w.ident = 8'd21; w.can_send = 0; w.last = 1;
            pending_words.push_back(w);
        end
        // class overflow: ten available paths, best ones past the limit
        for (int i = 0; i < 10; i++)
            pending_words.push_back(mk(8'(30 + i), STATUS_AVAIL, 32'(100 * (i + 1)),
                                       32'd7, i == 9));
        total_words = pending_words.size();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        // random rounds; a pause for a full drain midway
        for (int r = 0; total_words < 1550; r++) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 5);
            queue_round(n);
            total_words += n;
            if (r == 150) begin
                wait (pending_words.size() == 0 && !s_valid);
                hold_sender = 1;
                wait (expected_picks.size() == 0);
                hold_sender = 0;
            end
        end
        stim_done = 1;
    end

    // driver
    int send_gap;
    initial send_gap = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_accepted) begin
            // word holds until taken
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_valid  <= 1'b0;
        end else if (pending_words.size() > 0 && !hold_sender) begin
            s_word   <= pending_words.pop_front();
            s_valid  <= 1'b1;
            send_gap <= gap_len();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // receiver stalls
    int recv_gap;
    initial begin
        recv_gap   = 0;
        m_ready    = 1'b0;
        s_valid    = 1'b0;
        s_accepted = 1'b0;
        s_word     = '{default: '0};
    end
    always @(negedge aclk) begin
        if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready  <= 1'b1;
            recv_gap <= gap_len();
        end
    end

    // monitor: fold accepted path words, check accepted pick words
    always @(posedge aclk) begin
        pick_word_t e;
        s_accepted <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) score_path(s_word);
        if (aresetn && m_valid && m_ready) begin
            if (expected_picks.size() == 0) begin
                $display("%0t: unexpected pick word ident=%0d", $time, m_chosen_ident);
                error_count++;
            end else begin
                e = expected_picks.pop_front();
                if (m_found !== e.found) begin
                    $display("%0t: found exp %0d got %0d", $time, e.found, m_found);
                    error_count++;
                end
                if (m_chosen_ident !== e.ident) begin
                    $display("%0t: ident exp %0d got %0d", $time, e.ident, m_chosen_ident);
                    error_count++;
                end
                if (m_chosen_class !== e.cls) begin
                    $display("%0t: class exp %0d got %0d", $time, e.cls, m_chosen_class);
                    error_count++;
                end
                if (m_best_score !== e.score) begin
                    $display("%0t: score exp %0d got %0d", $time, e.score, m_best_score);
                    error_count++;
                end
                if (m_congestion_blocked !== e.blocked) begin
                    $display("%0t: blocked exp %0d got %0d", $time, e.blocked,
                             m_congestion_blocked);
                    error_count++;
                end
            end
        end
    end

    // end of run: drain, settle, verdict
    initial begin
        wait (stim_done);
        wait (pending_words.size() == 0 && !s_valid);
        wait (expected_picks.size() == 0);
        repeat (100) @(posedge aclk);
        if (error_count == 0 && expected_picks.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
